@@ rtl/phec_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phec_pkg
// Shared types and constants of the packet header event classifier.
// ----------------------------------------------------------------------------
package phec_pkg;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP     = 8'd1;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [3:0]  IHL_MIN        = 4'd5;
	localparam logic [5:0]  TCP_FLAGS_SYN  = 6'h02;
	localparam logic [15:0] DNS_PORT_RESET = 16'd53;

	localparam logic [15:0] MARK_SYN     = 16'h5914;
	localparam logic [15:0] MARK_DNS_IN  = 16'hD145;
	localparam logic [15:0] MARK_ICMP    = 16'h1C3F;
	localparam logic [15:0] MARK_DNS_OUT = 16'hD146;
	localparam logic [15:0] MARK_EGRESS  = 16'hE600;
	localparam logic [15:0] MARK_GENERAL = 16'h0000;

	// configuration register indexes
	localparam logic [0:0] CFG_EGRESS_MODE = 1'b0;
	localparam logic [0:0] CFG_DNS_PORT    = 1'b1;
	localparam int         CFG_DATA_W      = 16;

	// event queue
	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_beat_t;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [7:0]  ip_protocol;
		logic [15:0] marker;
		logic        last_in_run;
	} event_beat_t;

	// up to two events produced by one frame byte
	typedef struct packed {
		logic [1:0]  count;
		event_beat_t first;
		event_beat_t second;
	} event_push_t;

endpackage
`default_nettype wire

@@ rtl/phec_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phec_if
// Valid/ready channels for frame bytes in and events out.
// ----------------------------------------------------------------------------
interface phec_frame_if;
	logic                 valid;
	logic                 ready;
	phec_pkg::frame_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface phec_event_if;
	logic                 valid;
	logic                 ready;
	phec_pkg::event_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/phec_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phec_parser
// Input register, header field capture and event classification per byte.
// ----------------------------------------------------------------------------
module phec_parser (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [0:0]                      cfg_index,
	input  wire logic [phec_pkg::CFG_DATA_W-1:0] cfg_data,
	phec_frame_if.sink                           frame_stream,
	input  wire logic                            room,
	output phec_pkg::event_push_t                push
);

	logic                  valid_s1;
	phec_pkg::frame_beat_t beat_s1;

	logic        egress_q;
	logic [15:0] dns_port_q;

	logic [6:0]  off_q;
	logic        done_q;
	logic [7:0]  et_hi_q;
	logic [3:0]  hw_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q;
	logic [31:0] dst_q;
	logic [15:0] sp_q;
	logic [15:0] dp_q;
	logic [5:0]  flags_q;

	logic        step;
	logic        live;
	logic [7:0]  b;
	logic [6:0]  l4;
	logic [6:0]  rel;
	logic        done_a;
	logic        done_b;
	logic        at33;
	logic        icmp_hit;
	logic        l4_live;
	logic        udp_hit;
	logic        tcp_hit;
	logic        special;
	logic [15:0] main_mark;
	logic [15:0] spec_mark;
	logic [31:0] src_nxt;
	logic [31:0] dst_nxt;
	phec_pkg::event_beat_t ev0;
	phec_pkg::event_beat_t ev1;

	assign step               = valid_s1 && room;
	assign live               = step && !done_q;
	assign frame_stream.ready = !valid_s1 || room;
	assign b                  = beat_s1.frame_byte;
	assign l4                 = 7'd14 + {1'b0, hw_q, 2'b00};
	assign rel                = off_q - l4;

	always_comb begin
		done_a = done_q
			|| (off_q == 7'd13 && {et_hi_q, b} != phec_pkg::ETHERTYPE_IPV4)
			|| (off_q == 7'd14 && b[3:0] < phec_pkg::IHL_MIN);
		at33 = !done_a && off_q == 7'd33;
		icmp_hit = at33 && proto_q == phec_pkg::PROTO_ICMP && !egress_q;
		done_b = done_a || (at33 && (icmp_hit
			|| (proto_q != phec_pkg::PROTO_TCP && proto_q != phec_pkg::PROTO_UDP)));
		l4_live = !done_b && off_q > 7'd33 && off_q >= l4;
		udp_hit = live && l4_live && proto_q == phec_pkg::PROTO_UDP && rel == 7'd7;
		tcp_hit = live && l4_live && proto_q == phec_pkg::PROTO_TCP && rel == 7'd19;

		src_nxt = (off_q >= 7'd26 && off_q <= 7'd29) ? {src_q[23:0], b} : src_q;
		dst_nxt = (off_q >= 7'd30 && off_q <= 7'd33) ? {dst_q[23:0], b} : dst_q;

		main_mark = egress_q ? phec_pkg::MARK_EGRESS : phec_pkg::MARK_GENERAL;
		if (proto_q == phec_pkg::PROTO_UDP) begin
			spec_mark = egress_q ? phec_pkg::MARK_DNS_OUT : phec_pkg::MARK_DNS_IN;
			special   = egress_q ? (dp_q == dns_port_q)
				: (sp_q == dns_port_q || dp_q == dns_port_q);
		end else begin
			spec_mark = phec_pkg::MARK_SYN;
			special   = !egress_q && flags_q == phec_pkg::TCP_FLAGS_SYN;
		end

		ev0.source_address = src_nxt;
		ev0.dest_address   = dst_nxt;
		ev0.ip_protocol    = proto_q;
		ev0.source_port    = icmp_hit ? 16'd0 : sp_q;
		ev0.dest_port      = icmp_hit ? 16'd0 : dp_q;
		ev0.marker         = icmp_hit ? phec_pkg::MARK_ICMP
			: (special ? spec_mark : main_mark);
		ev0.last_in_run    = icmp_hit || !special;

		ev1                = ev0;
		ev1.marker         = main_mark;
		ev1.last_in_run    = 1'b1;

		push.first  = ev0;
		push.second = ev1;
		if (live && icmp_hit) begin
			push.count = 2'd1;
		end else if (udp_hit || tcp_hit) begin
			push.count = special ? 2'd2 : 2'd1;
		end else begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			egress_q   <= 1'b0;
			dns_port_q <= phec_pkg::DNS_PORT_RESET;
			off_q      <= 7'd0;
			done_q     <= 1'b0;
		end else begin
			if (frame_stream.ready) begin
				valid_s1 <= frame_stream.valid;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					phec_pkg::CFG_EGRESS_MODE: egress_q <= cfg_data[0];
					phec_pkg::CFG_DNS_PORT:    dns_port_q <= cfg_data;
					default: ;
				endcase
			end
			if (step) begin
				if (beat_s1.frame_end) begin
					off_q  <= 7'd0;
					done_q <= 1'b0;
				end else if (live) begin
					done_q <= done_b || udp_hit || tcp_hit;
					if (off_q != 7'd127) begin
						off_q <= off_q + 7'd1;
					end
				end
			end
		end
	end

	// header fields: always written before they are read within a frame
	always_ff @(posedge clk) begin
		if (frame_stream.ready && frame_stream.valid) begin
			beat_s1 <= frame_stream.payload;
		end
		if (live) begin
			src_q <= src_nxt;
			dst_q <= dst_nxt;
			if (off_q == 7'd12) begin
				et_hi_q <= b;
			end
			if (off_q == 7'd14) begin
				hw_q <= b[3:0];
			end
			if (off_q == 7'd23) begin
				proto_q <= b;
			end
			if (l4_live && (rel == 7'd0 || rel == 7'd1)) begin
				sp_q <= {sp_q[7:0], b};
			end
			if (l4_live && (rel == 7'd2 || rel == 7'd3)) begin
				dp_q <= {dp_q[7:0], b};
			end
			if (l4_live && rel == 7'd13) begin
				flags_q <= b[5:0];
			end
		end
	end

	a_no_event_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> valid_s1 && !done_q && room)
		else $error("event from a finished frame");

	a_done_after_event: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |=> done_q || off_q == 7'd0)
		else $error("frame not closed after its events");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two events for one byte");

endmodule
`default_nettype wire

@@ rtl/phec_event_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// phec_event_queue
// Small register queue that takes up to two events a cycle while it has room for two, drains one beat.
// ----------------------------------------------------------------------------
module phec_event_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire phec_pkg::event_push_t push,
	output logic                       room,
	phec_event_if.source               event_stream
);

	localparam int PTR_W = $clog2(phec_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(phec_pkg::QUEUE_DEPTH + 1);

	phec_pkg::event_beat_t entry_q [phec_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  pop;

	assign room                 = count_q <= CNT_W'(phec_pkg::QUEUE_DEPTH - 2);
	assign event_stream.valid   = count_q != '0;
	assign event_stream.payload = entry_q[rd_ptr_q];
	assign pop                  = event_stream.valid && event_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_q + PTR_W'(1)] <= push.second;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("event queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(phec_pkg::QUEUE_DEPTH))
		else $error("event queue count out of range");

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		event_stream.valid && !event_stream.ready
		|=> event_stream.valid && $stable(event_stream.payload))
		else $error("event beat changed while stalled");

endmodule
`default_nettype wire

@@ rtl/packet_header_event_classifier.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// packet_header_event_classifier
// Parses Ethernet/IPv4/TCP/UDP headers from a byte stream and emits events.
// ----------------------------------------------------------------------------
// frame_stream takes one frame byte per beat, frame_end on the last byte.
// event_stream gives one event per beat; last_in_run marks the final event
// caused by a byte (at most two per byte, at most one run per frame).
// cfg_wr_en/cfg_index/cfg_data write egress_mode (index 0) and
// dns_port_number (index 1); write them while no frame is in flight.
// Throughput: one byte per cycle while the queue has room. Each byte
// passes an input register, then the header logic pushes its events into a
// four-entry queue, whose head drives event_stream.
// A byte is held in the input register only while the queue has fewer than
// two free entries, so a stalled receiver backs up into frame_stream after
// the queue fills.
// Reset clears the parser to the start of a frame, sets ingress rules and
// DNS port 53, and empties the queue.
// ----------------------------------------------------------------------------
module packet_header_event_classifier (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [0:0]                      cfg_index,
	input  wire logic [phec_pkg::CFG_DATA_W-1:0] cfg_data,
	phec_frame_if.sink                           frame_stream,
	phec_event_if.source                         event_stream
);

	phec_pkg::event_push_t push;
	logic                  room;

	phec_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.frame_stream (frame_stream),
		.room         (room),
		.push         (push)
	);

	phec_event_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.event_stream (event_stream)
	);

endmodule
`default_nettype wire

@@ tb/packet_header_event_classifier_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// packet_header_event_classifier_tb
// Drives Ethernet frames byte by byte into the header classifier and checks
// each emitted event, first for a short table of hand-built frames against
// its listed events or a cycle-free model of the parser, then against the
// model on random traffic, changing stall patterns and register settings.
// ----------------------------------------------------------------------------
module packet_header_event_classifier_tb;

	localparam int CLK_PERIOD      = 10;
	localparam int DRAIN_CYCLES    = 4;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int SEGMENT_BYTES   = 20;
	localparam int SEGMENT_EVENTS  = 1;
	localparam int MAX_REPORTS     = 10;

	typedef struct {
		logic [15:0] ethertype;
		logic [7:0]  ver_ihl;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] l4_src;
		logic [15:0] l4_dst;
		logic [7:0]  flags;
		int          length;
	} frame_spec_t;

	// typed_events < 0: events come from the parser model
	typedef struct {
		bit          egress;
		logic [15:0] dns;
		frame_spec_t frame;
		int          typed_events;
		logic [15:0] mark;
	} directed_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [0:0]                      cfg_index;
	logic [phec_pkg::CFG_DATA_W-1:0] cfg_data;

	phec_frame_if frame_if ();
	phec_event_if event_if ();

	packet_header_event_classifier uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.frame_stream (frame_if),
		.event_stream (event_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	bit          cfg_egress;
	logic [15:0] cfg_dns;

	logic [6:0]  p_offset;
	logic [15:0] p_ethertype;
	logic [3:0]  p_ihl;
	logic [7:0]  p_proto;
	logic [31:0] p_src;
	logic [31:0] p_dst;
	logic [15:0] p_sport;
	logic [15:0] p_dport;
	logic [5:0]  p_flags;
	bit          p_done;

	phec_pkg::event_beat_t expected_events[$];
	directed_row_t         directed_rows[$];
	logic [7:0]            frame_bytes[$];

	bit table_owns_events;
	int events_predicted;
	int bytes_sent;
	int error_count;
	int idle_cycles;
	int src_idle_pct;
	int sink_idle_pct;
	int hold_requests;
	int hold_served;
	int hold_left;

	function automatic void parser_clear();
		p_offset    = '0;
		p_ethertype = '0;
		p_ihl       = '0;
		p_proto     = '0;
		p_src       = '0;
		p_dst       = '0;
		p_sport     = '0;
		p_dport     = '0;
		p_flags     = '0;
		p_done      = 1'b0;
	endfunction

	function automatic phec_pkg::event_beat_t make_event(logic [15:0] sport,
			logic [15:0] dport, logic [15:0] mark);
		phec_pkg::event_beat_t e;
		e.source_address = p_src;
		e.dest_address   = p_dst;
		e.source_port    = sport;
		e.dest_port      = dport;
		e.ip_protocol    = p_proto;
		e.marker         = mark;
		e.last_in_run    = 1'b0;
		return e;
	endfunction

	function automatic void classify_byte(phec_pkg::frame_beat_t beat);
		phec_pkg::event_beat_t found[$];
		int                    off;
		int                    l4;
		int                    rel;
		logic [7:0]            b;
		b = beat.frame_byte;
		if (!p_done) begin
			off = p_offset;
			l4  = 14 + 4 * p_ihl;
			if (off == 12) p_ethertype = {b, 8'h00};
			if (off == 13) begin
				p_ethertype[7:0] = b;
				if (p_ethertype != phec_pkg::ETHERTYPE_IPV4) p_done = 1'b1;
			end
			if (off == 14) begin
				p_ihl = b[3:0];
				l4    = 14 + 4 * p_ihl;
				if (p_ihl < phec_pkg::IHL_MIN) p_done = 1'b1;
			end
			if (off == 23) p_proto = b;
			if (off >= 26 && off <= 29) p_src = {p_src[23:0], b};
			if (off >= 30 && off <= 33) p_dst = {p_dst[23:0], b};
			if (!p_done && off == 33) begin
				if (p_proto == phec_pkg::PROTO_ICMP && !cfg_egress) begin
					found.push_back(make_event(16'h0000, 16'h0000, phec_pkg::MARK_ICMP));
					p_done = 1'b1;
				end else if (p_proto != phec_pkg::PROTO_TCP
						&& p_proto != phec_pkg::PROTO_UDP) begin
					p_done = 1'b1;
				end
			end
			if (!p_done && off > 33 && off >= l4) begin
				rel = off - l4;
				if (rel == 0 || rel == 1) p_sport = {p_sport[7:0], b};
				if (rel == 2 || rel == 3) p_dport = {p_dport[7:0], b};
				if (rel == 13) p_flags = b[5:0];
				if (p_proto == phec_pkg::PROTO_UDP && rel == 7) begin
					if (!cfg_egress) begin
						if (p_sport == cfg_dns || p_dport == cfg_dns)
							found.push_back(make_event(p_sport, p_dport,
								phec_pkg::MARK_DNS_IN));
						found.push_back(make_event(p_sport, p_dport, phec_pkg::MARK_GENERAL));
					end else begin
						if (p_dport == cfg_dns)
							found.push_back(make_event(p_sport, p_dport,
								phec_pkg::MARK_DNS_OUT));
						found.push_back(make_event(p_sport, p_dport, phec_pkg::MARK_EGRESS));
					end
					p_done = 1'b1;
				end else if (p_proto == phec_pkg::PROTO_TCP && rel == 19) begin
					if (!cfg_egress) begin
						if (p_flags == phec_pkg::TCP_FLAGS_SYN)
							found.push_back(make_event(p_sport, p_dport, phec_pkg::MARK_SYN));
						found.push_back(make_event(p_sport, p_dport, phec_pkg::MARK_GENERAL));
					end else begin
						found.push_back(make_event(p_sport, p_dport, phec_pkg::MARK_EGRESS));
					end
					p_done = 1'b1;
				end
			end
			if (p_offset < 7'd127) p_offset = p_offset + 7'd1;
		end
		if (found.size() > 0) found[found.size() - 1].last_in_run = 1'b1;
		events_predicted += found.size();
		if (!table_owns_events) begin
			foreach (found[i]) expected_events.push_back(found[i]);
		end
		if (beat.frame_end) parser_clear();
	endfunction

	function automatic string describe(phec_pkg::event_beat_t e);
		return $sformatf("src=%h dst=%h sport=%h dport=%h proto=%h marker=%h last=%b",
			e.source_address, e.dest_address, e.source_port, e.dest_port,
			e.ip_protocol, e.marker, e.last_in_run);
	endfunction

	function automatic void add_directed(bit egress, logic [15:0] dns, logic [15:0] etype,
			logic [7:0] ver_ihl, logic [7:0] proto, logic [31:0] src, logic [31:0] dst,
			logic [15:0] sport, logic [15:0] dport, logic [7:0] flags, int length,
			int typed_events, logic [15:0] mark);
		directed_row_t r;
		r.egress          = egress;
		r.dns             = dns;
		r.frame.ethertype = etype;
		r.frame.ver_ihl   = ver_ihl;
		r.frame.protocol  = proto;
		r.frame.src_ip    = src;
		r.frame.dst_ip    = dst;
		r.frame.l4_src    = sport;
		r.frame.l4_dst    = dport;
		r.frame.flags     = flags;
		r.frame.length    = length;
		r.typed_events    = typed_events;
		r.mark            = mark;
		directed_rows.push_back(r);
	endfunction

	function automatic void build_frame(frame_spec_t s);
		int         l4;
		logic [7:0] b;
		frame_bytes.delete();
		l4 = 14 + 4 * s.ver_ihl[3:0];
		for (int i = 0; i < s.length; i++) begin
			b = 8'($urandom);
			case (i)
				12: b = s.ethertype[15:8];
				13: b = s.ethertype[7:0];
				14: b = s.ver_ihl;
				23: b = s.protocol;
				26, 27, 28, 29: b = s.src_ip[8 * (29 - i) +: 8];
				30, 31, 32, 33: b = s.dst_ip[8 * (33 - i) +: 8];
				default: begin
					if (i >= 34 && i >= l4) begin
						case (i - l4)
							0: b = s.l4_src[15:8];
							1: b = s.l4_src[7:0];
							2: b = s.l4_dst[15:8];
							3: b = s.l4_dst[7:0];
							13: b = s.flags;
							default: ;
						endcase
					end
				end
			endcase
			frame_bytes.push_back(b);
		end
	endfunction

	function automatic frame_spec_t random_frame_spec();
		frame_spec_t s;
		int unsigned kind;
		int unsigned pick;
		int          needed;
		logic [3:0]  ihl;
		kind = $urandom_range(99);
		pick = $urandom_range(99);
		ihl = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(15, 5));
		s.ethertype = phec_pkg::ETHERTYPE_IPV4;
		s.ver_ihl   = {($urandom_range(7) == 0) ? 4'($urandom) : 4'h4, ihl};
		s.protocol  = (pick < 40) ? phec_pkg::PROTO_TCP : (pick < 80) ? phec_pkg::PROTO_UDP :
			(pick < 95) ? phec_pkg::PROTO_ICMP : 8'($urandom);
		s.src_ip    = $urandom;
		s.dst_ip    = $urandom;
		s.l4_src    = ($urandom_range(2) == 0) ? cfg_dns : 16'($urandom);
		s.l4_dst    = ($urandom_range(2) == 0) ? cfg_dns : 16'($urandom);
		s.flags     = ($urandom_range(2) == 0) ? {2'($urandom), phec_pkg::TCP_FLAGS_SYN}
			: 8'($urandom);
		if (s.protocol == phec_pkg::PROTO_TCP) needed = 14 + 4 * ihl + 20;
		else if (s.protocol == phec_pkg::PROTO_UDP) needed = 14 + 4 * ihl + 8;
		else needed = 34;
		s.length = needed + $urandom_range(4);
		if (kind < 12) begin
			s.length = $urandom_range(needed - 1, 1);
		end else if (kind < 20) begin
			s.ethertype = 16'($urandom);
			s.length    = $urandom_range(60, 14);
		end else if (kind < 26) begin
			s.ver_ihl[3:0] = 4'($urandom_range(4));
		end else if (kind < 28) begin
			s.length = $urandom_range(160, 128);
		end
		return s;
	endfunction

	task automatic send_frame();
		phec_pkg::frame_beat_t beat;
		foreach (frame_bytes[i]) begin
			beat.frame_byte = frame_bytes[i];
			beat.frame_end  = (i == frame_bytes.size() - 1);
			while ($urandom_range(99) < src_idle_pct) begin
				frame_if.valid <= 1'b0;
				@(negedge clk);
			end
			frame_if.valid   <= 1'b1;
			frame_if.payload <= beat;
			@(posedge clk);
			while (!frame_if.ready) @(posedge clk);
			@(negedge clk);
			bytes_sent++;
		end
	endtask

	task automatic set_config(bit egress, logic [15:0] dns);
		frame_if.valid <= 1'b0;
		@(negedge clk);
		while (expected_events.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= phec_pkg::CFG_EGRESS_MODE;
		cfg_data  <= phec_pkg::CFG_DATA_W'(egress);
		@(negedge clk);
		cfg_index <= phec_pkg::CFG_DNS_PORT;
		cfg_data  <= dns;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// model the parser on every byte beat, score every event beat
	always @(posedge clk or negedge arst_n) begin
		phec_pkg::event_beat_t want;
		if (!arst_n) begin
			cfg_egress = 1'b0;
			cfg_dns    = phec_pkg::DNS_PORT_RESET;
			parser_clear();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					phec_pkg::CFG_EGRESS_MODE: cfg_egress = cfg_data[0];
					phec_pkg::CFG_DNS_PORT: cfg_dns = cfg_data;
					default: ;
				endcase
			end
			if (frame_if.valid && frame_if.ready) classify_byte(frame_if.payload);
			if (event_if.valid && event_if.ready) begin
				if (expected_events.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected event: %s", describe(event_if.payload));
				end else begin
					want = expected_events.pop_front();
					if (event_if.payload !== want) begin
						error_count++;
						if (error_count <= MAX_REPORTS) begin
							$display("event mismatch: expected %s", describe(want));
							$display("                actual   %s",
								describe(event_if.payload));
						end
					end
				end
			end
		end
	end

	// hold off the event sink on request, else stall at random
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			event_if.ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_OFF_CYCLES - 1;
			event_if.ready <= 1'b0;
		end else begin
			event_if.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((frame_if.valid && frame_if.ready) || (event_if.valid && event_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		directed_row_t         row;
		frame_spec_t           spec;
		phec_pkg::event_beat_t ev;
		bit                    cur_egress;
		logic [15:0]           cur_dns;
		bit                    seg_egress;
		logic [15:0]           seg_dns;
		int                    seg;
		int                    seg_bytes;
		int                    seg_events;
		arst_n           = 1'b0;
		cfg_wr_en        = 1'b0;
		cfg_index        = phec_pkg::CFG_EGRESS_MODE;
		cfg_data         = '0;
		frame_if.valid   = 1'b0;
		frame_if.payload = '0;
		event_if.ready   = 1'b0;
		src_idle_pct     = 13;
		sink_idle_pct    = 73;
		cur_egress       = 1'b0;
		cur_dns          = phec_pkg::DNS_PORT_RESET;

		// ingress, default DNS port
		add_directed(0, 16'd53, 16'h0800, 8'h45, phec_pkg::PROTO_ICMP, 32'hFFFF_FFFF,
			32'h0000_0000, 16'h0, 16'h0, 8'h00, 34, 1, phec_pkg::MARK_ICMP);
		add_directed(0, 16'd53, 16'h0800, 8'h45, phec_pkg::PROTO_ICMP, 32'h0000_0000,
			32'hFFFF_FFFF, 16'h0, 16'h0, 8'h00, 40, 1, phec_pkg::MARK_ICMP);
		add_directed(0, 16'd53, 16'h86DD, 8'h45, phec_pkg::PROTO_UDP, 32'h0A00_0001,
			32'h0A00_0002, 16'd53, 16'd53, 8'h00, 40, 0, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0801, 8'h45, phec_pkg::PROTO_ICMP, 32'h0A00_0001,
			32'h0A00_0002, 16'h0, 16'h0, 8'h00, 40, 0, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h44, phec_pkg::PROTO_TCP, 32'h0A00_0001,
			32'h0A00_0002, 16'd80, 16'd80, 8'h02, 40, 0, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h40, phec_pkg::PROTO_UDP, 32'h0A00_0001,
			32'h0A00_0002, 16'd53, 16'd53, 8'h00, 50, 0, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h45, phec_pkg::PROTO_TCP, 32'h0A00_0001,
			32'hC0A8_0001, 16'h0000, 16'hFFFF, 8'h02, 54, -1, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h4F, phec_pkg::PROTO_TCP, 32'hC0A8_0001,
			32'h0A00_0001, 16'hFFFF, 16'h0000, 8'hC2, 100, -1, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h45, phec_pkg::PROTO_TCP, 32'h8000_0000,
			32'h7FFF_FFFF, 16'd443, 16'd1025, 8'h12, 54, -1, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h45, phec_pkg::PROTO_UDP, 32'h0808_0808,
			32'hC0A8_0101, 16'd53, 16'd1024, 8'h00, 42, -1, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h46, phec_pkg::PROTO_UDP, 32'hC0A8_0101,
			32'h0808_0808, 16'd5353, 16'd53, 8'h00, 50, -1, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h45, phec_pkg::PROTO_UDP, 32'h0102_0304,
			32'h0506_0708, 16'd1234, 16'd80, 8'h00, 42, -1, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h45, phec_pkg::PROTO_UDP, 32'h0102_0304,
			32'h0506_0708, 16'd53, 16'd53, 8'h00, 41, 0, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h45, phec_pkg::PROTO_ICMP, 32'h0102_0304,
			32'h0506_0708, 16'h0, 16'h0, 8'h00, 33, 0, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h45, 8'h00, 32'h0102_0304, 32'h0506_0708,
			16'h0, 16'h0, 8'h00, 40, 0, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h45, 8'hFF, 32'h0102_0304, 32'h0506_0708,
			16'h0, 16'h0, 8'h00, 34, 0, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h45, phec_pkg::PROTO_UDP, 32'hAAAA_5555,
			32'h5555_AAAA, 16'd53, 16'd9, 8'h00, 140, -1, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'd53, 16'h0800, 8'h45, phec_pkg::PROTO_ICMP, 32'h0, 32'h0,
			16'h0, 16'h0, 8'h00, 1, 0, phec_pkg::MARK_GENERAL);
		// egress, DNS port zero
		add_directed(1, 16'd0, 16'h0800, 8'h45, phec_pkg::PROTO_UDP, 32'h0A01_0203,
			32'h0A04_0506, 16'd1, 16'd0, 8'h00, 42, -1, phec_pkg::MARK_GENERAL);
		add_directed(1, 16'd0, 16'h0800, 8'h45, phec_pkg::PROTO_UDP, 32'h0A01_0203,
			32'h0A04_0506, 16'd0, 16'd5, 8'h00, 42, -1, phec_pkg::MARK_GENERAL);
		add_directed(1, 16'd0, 16'h0800, 8'h45, phec_pkg::PROTO_TCP, 32'h0A01_0203,
			32'h0A04_0506, 16'd0, 16'd0, 8'h02, 54, -1, phec_pkg::MARK_GENERAL);
		add_directed(1, 16'd0, 16'h0800, 8'h45, phec_pkg::PROTO_ICMP, 32'h0A01_0203,
			32'h0A04_0506, 16'h0, 16'h0, 8'h00, 40, 0, phec_pkg::MARK_GENERAL);
		// ingress, DNS port at the top of the range
		add_directed(0, 16'hFFFF, 16'h0800, 8'h45, phec_pkg::PROTO_UDP, 32'hFEDC_BA98,
			32'h0123_4567, 16'hFFFF, 16'h0000, 8'h00, 42, -1, phec_pkg::MARK_GENERAL);
		add_directed(0, 16'hFFFF, 16'h0800, 8'hF5, phec_pkg::PROTO_ICMP, 32'hFEDC_BA98,
			32'h0123_4567, 16'h0, 16'h0, 8'h00, 34, 1, phec_pkg::MARK_ICMP);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			row = directed_rows[r];
			if (row.egress != cur_egress || row.dns != cur_dns) begin
				set_config(row.egress, row.dns);
				cur_egress = row.egress;
				cur_dns    = row.dns;
			end
			table_owns_events = (row.typed_events >= 0);
			for (int n = 0; n < row.typed_events; n++) begin
				ev.source_address = row.frame.src_ip;
				ev.dest_address   = row.frame.dst_ip;
				ev.source_port    = 16'h0000;
				ev.dest_port      = 16'h0000;
				ev.ip_protocol    = row.frame.protocol;
				ev.marker         = row.mark;
				ev.last_in_run    = (n == row.typed_events - 1);
				expected_events.push_back(ev);
			end
			build_frame(row.frame);
			send_frame();
		end
		table_owns_events = 1'b0;

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 13;
					sink_idle_pct = 73;
				end
				1: begin
					src_idle_pct  = 73;
					sink_idle_pct = 13;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int half = 0; half < 2; half++) begin
				seg        = 2 * phase + half;
				seg_egress = (seg == 0 || seg == 2 || seg == 5);
				case (seg)
					0: seg_dns = 16'hFFFF;
					1: seg_dns = 16'h0000;
					3: seg_dns = phec_pkg::DNS_PORT_RESET;
					default: seg_dns = 16'($urandom);
				endcase
				set_config(seg_egress, seg_dns);
				// stall the event sink long enough to back up into the byte input
				if (phase == 2 && half == 0) hold_requests++;
				seg_bytes  = bytes_sent;
				seg_events = events_predicted;
				while (bytes_sent - seg_bytes < SEGMENT_BYTES ||
						events_predicted - seg_events < SEGMENT_EVENTS ||
						hold_served != hold_requests || hold_left > 0) begin
					spec = random_frame_spec();
					build_frame(spec);
					send_frame();
				end
			end
		end

		frame_if.valid <= 1'b0;
		while (expected_events.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
